[sv/tia_pkg.sv]
// Package for the table-interpolated atan2 core: shared types, constants and
// the arctangent ROM. Depends on nothing; all but tia_if import it.
package tia_pkg;

   localparam int unsigned QUOT_W     = 10;  // ratio bits kept by the divider
   localparam int unsigned DIV_STEPS  = QUOT_W;
   localparam int unsigned ANGLE_W    = 11;  // first-quadrant angle, 0..1571
   localparam int unsigned OUT_W      = 14;

   localparam logic [ANGLE_W-1:0] HALF_PI_MRAD = 11'd1571;
   localparam logic [ANGLE_W-1:0] ROM_LAST     = 11'd1446;
   localparam logic [QUOT_W-1:0]  RATIO_LIMIT  = 10'd256;
   localparam logic signed [OUT_W-1:0] OUT_HALF_PI = 14'sd1571;
   localparam logic signed [OUT_W-1:0] OUT_PI      = 14'sd3142;
   localparam logic signed [OUT_W-1:0] OUT_TWO_PI  = 14'sd6283;

   typedef enum logic [1:0] {
      KIND_NORMAL,
      KIND_X_ZERO,
      KIND_Y_ZERO
   } tia_kind_type;

   // One classified vector as it leaves the front part.
   typedef struct packed {
      tia_kind_type kind;
      logic         y_neg;
      logic         x_neg;
      logic         ovf;     // |y| >= 32*|x|: ratio beyond the divider range
      logic [15:0]  ay;
      logic [15:0]  ax;
   } tia_item_type;

   // Arctangent ROM, 17 entries, in milliradians.
   function automatic logic [ANGLE_W-1:0] atan_rom(input logic [4:0] idx);
      logic [ANGLE_W-1:0] v;
      case (idx)
         5'd0:  v = 11'd0;
         5'd1:  v = 11'd464;
         5'd2:  v = 11'd785;
         5'd3:  v = 11'd983;
         5'd4:  v = 11'd1107;
         5'd5:  v = 11'd1190;
         5'd6:  v = 11'd1249;
         5'd7:  v = 11'd1292;
         5'd8:  v = 11'd1326;
         5'd9:  v = 11'd1352;
         5'd10: v = 11'd1373;
         5'd11: v = 11'd1391;
         5'd12: v = 11'd1406;
         5'd13: v = 11'd1418;
         5'd14: v = 11'd1429;
         5'd15: v = 11'd1438;
         5'd16: v = 11'd1446;
         default: v = 11'd1446;
      endcase
      return v;
   endfunction

endpackage

[sv/tia_if.sv]
// Valid/ready channel interfaces for the atan2 core: vector requests and
// angle responses. Depends on nothing.
interface tia_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] y_in;
   logic signed [15:0] x_in;

   modport source (output valid, output y_in, output x_in, input ready);
   modport sink   (input valid, input y_in, input x_in, output ready);
endinterface

interface tia_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [13:0] angle_mrad;

   modport source (output valid, output angle_mrad, input ready);
   modport sink   (input valid, input angle_mrad, output ready);
endinterface

[sv/tia_front.sv]
// Front part of the atan2 core: accepts a vector, classifies it and forms
// magnitudes. Depends on tia_pkg and tia_req_if.
module tia_front import tia_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tia_req_if.sink       req_ch,
   output logic          out_valid,
   input  logic          out_ready,
   output tia_item_type  out_item
);

   logic         valid_ff, valid_in;
   tia_item_type item_ff, item_in;
   logic [15:0]  ay, ax;

   assign req_ch.ready = !valid_ff || out_ready;

   always_comb begin
      // Negating the most negative value yields 0x8000, which is 32768 unsigned.
      ay = req_ch.y_in[15] ? 16'(-req_ch.y_in) : 16'(req_ch.y_in);
      ax = req_ch.x_in[15] ? 16'(-req_ch.x_in) : 16'(req_ch.x_in);
      item_in.y_neg = req_ch.y_in[15];
      item_in.x_neg = req_ch.x_in[15];
      item_in.ay    = ay;
      item_in.ax    = ax;
      item_in.ovf   = {5'd0, ay} >= {ax, 5'd0};
      if (ax == 16'd0) begin
         item_in.kind = KIND_X_ZERO;
      end else if (ay == 16'd0) begin
         item_in.kind = KIND_Y_ZERO;
      end else begin
         item_in.kind = KIND_NORMAL;
      end
      valid_in = req_ch.ready ? req_ch.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/tia_queue.sv]
// Short queue between the front and back parts of the atan2 core.
// Depends on tia_pkg for the item type.
module tia_queue import tia_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tia_item_type  in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output tia_item_type  out_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   tia_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[sv/tia_back.sv]
// Back part of the atan2 core: pipelined ratio divider, ROM interpolation,
// quadrant fold and output register. Depends on tia_pkg and tia_rsp_if.
module tia_back import tia_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tia_item_type  in_item,
   tia_rsp_if.source     rsp_ch
);

   typedef struct packed {
      tia_kind_type      kind;
      logic              y_neg;
      logic              x_neg;
      logic              ovf;
      logic [15:0]       d;
      logic [15:0]       r;
      logic [QUOT_W-1:0] q;
      logic [QUOT_W-1:0] nbits;   // dividend bits still to bring down
   } tia_div_type;

   typedef struct packed {
      tia_kind_type       kind;
      logic               y_neg;
      logic               x_neg;
      logic [ANGLE_W-1:0] a;
   } tia_ang_type;

   // One restoring division step: bring down a bit, subtract if it fits.
   function automatic tia_div_type div_step(input tia_div_type s);
      tia_div_type o;
      logic [16:0] t;
      logic        ge;
      o       = s;
      t       = {s.r, s.nbits[QUOT_W-1]};
      ge      = t >= {1'b0, s.d};
      o.r     = ge ? 16'(t - {1'b0, s.d}) : t[15:0];
      o.q     = {s.q[QUOT_W-2:0], ge};
      o.nbits = {s.nbits[QUOT_W-2:0], 1'b0};
      return o;
   endfunction

   logic        advance;
   logic        div_valid_ff [DIV_STEPS+1];
   tia_div_type div_ff [DIV_STEPS+1];
   tia_div_type div_first;
   logic        ang_valid_ff;
   tia_ang_type ang_ff, ang_in;
   logic        out_valid_ff;
   logic signed [OUT_W-1:0] out_angle_ff, out_angle_in;

   logic [QUOT_W-1:0]  ratio, over;
   logic [ANGLE_W-1:0] lo, hi, diff, ext;
   logic [14:0]        prod;
   logic signed [OUT_W-1:0] a_s;

   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign in_ready = advance;

   always_comb begin
      // The dividend is |y|*32; its top eleven bits start the remainder.
      div_first.kind  = in_item.kind;
      div_first.y_neg = in_item.y_neg;
      div_first.x_neg = in_item.x_neg;
      div_first.ovf   = in_item.ovf;
      div_first.d     = in_item.ax;
      div_first.r     = {5'd0, in_item.ay[15:5]};
      div_first.q     = '0;
      div_first.nbits = {in_item.ay[4:0], 5'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
         ang_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= in_valid;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
         ang_valid_ff <= div_valid_ff[DIV_STEPS];
         out_valid_ff <= ang_valid_ff;
      end
      if (advance) begin
         div_ff[0] <= div_first;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            div_ff[k] <= div_step(div_ff[k-1]);
         end
         ang_ff       <= ang_in;
         out_angle_ff <= out_angle_in;
      end
   end

   // First-quadrant angle from the ratio.
   always_comb begin
      ratio = div_ff[DIV_STEPS].ovf ? '1 : div_ff[DIV_STEPS].q;
      lo    = atan_rom({1'b0, ratio[7:4]});
      hi    = atan_rom({1'b0, ratio[7:4]} + 5'd1);
      diff  = hi - lo;
      prod  = 15'(diff) * 15'(ratio[3:0]);
      over  = ratio - RATIO_LIMIT;
      ext   = ROM_LAST + ANGLE_W'(over[QUOT_W-1:2]);
      ang_in.kind  = div_ff[DIV_STEPS].kind;
      ang_in.y_neg = div_ff[DIV_STEPS].y_neg;
      ang_in.x_neg = div_ff[DIV_STEPS].x_neg;
      if (ratio < RATIO_LIMIT) begin
         ang_in.a = lo + prod[14:4];
      end else if (ext > HALF_PI_MRAD) begin
         ang_in.a = HALF_PI_MRAD;
      end else begin
         ang_in.a = ext;
      end
   end

   // Quadrant fold into 0..2pi; the axis cases are handled by kind, x zero giving +-pi/2.
   always_comb begin
      a_s = signed'({3'd0, ang_ff.a});
      case (ang_ff.kind)
         KIND_X_ZERO: out_angle_in = ang_ff.y_neg ? -OUT_HALF_PI : OUT_HALF_PI;
         KIND_Y_ZERO: out_angle_in = ang_ff.x_neg ? OUT_PI : '0;
         KIND_NORMAL: begin
            if (ang_ff.x_neg) begin
               out_angle_in = ang_ff.y_neg ? OUT_PI + a_s : OUT_PI - a_s;
            end else begin
               out_angle_in = ang_ff.y_neg ? OUT_TWO_PI - a_s : a_s;
            end
         end
         default: out_angle_in = '0;
      endcase
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.angle_mrad = out_angle_ff;

endmodule

[sv/table_interp_atan2_core.sv]
// Top level of the table-interpolated atan2 core: front, queue and back.
// Depends on tia_pkg, tia_if, tia_front, tia_queue and tia_back.
//
// Usage: a vector (y_in, x_in), both signed 16-bit, enters on the req_ch
// channel and is accepted at a rising clock edge where valid and ready are
// both high. One item comes back on rsp_ch per vector, in order, carrying
// angle_mrad: the angle in milliradians folded into 0..6283, or +-1571 when
// x is zero.
//
// Throughput is one item per cycle unless the receiver stalls rsp_ch. From
// acceptance to rsp_ch.valid an item passes, when the queue is empty, through
// the front register, the queue, the divider input register, the divider pipeline
// (one restoring step and one quotient bit per stage, the division |y|*32/|x|
// being the longest chain), the ROM interpolation register and the quadrant
// fold into the output register.
//
// When the receiver stalls, the back pipeline holds in place and the queue
// absorbs QUEUE_DEPTH items plus one in the front register before req_ch.ready
// drops. Synchronous reset empties every stage and the queue; the data
// registers are not reset, and req_ch.ready is high once reset is released.
module table_interp_atan2_core import tia_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   tia_req_if.sink    req_ch,
   tia_rsp_if.source  rsp_ch
);

   // Front to queue.
   logic         front_valid;
   logic         front_ready;
   tia_item_type front_item;

   // Queue to back.
   logic         back_valid;
   logic         back_ready;
   tia_item_type back_item;

   tia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   tia_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   tia_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (back_valid),
      .in_ready (back_ready),
      .in_item  (back_item),
      .rsp_ch   (rsp_ch)
   );

endmodule
